// File: rtl/mcdd_pkg.sv
// Shared types, codes and lookup functions for the morphing clock digit drawer.
// Used by mcdd_ctrl, mcdd_dp and the top level; depends on nothing.
`default_nettype none
package mcdd_pkg;

  localparam int COLOR_WIDTH_DEF = 16;
  localparam int NUM_DIGITS      = 6;
  localparam int DIG_W           = 3;
  localparam int POS_W           = 7;

  localparam logic [1:0] KIND_UPD    = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_REINIT = 2'd2;

  localparam logic [1:0] OP_PIX  = 2'd0;
  localparam logic [1:0] OP_LINE = 2'd1;
  localparam logic [1:0] OP_BG   = 2'd2;

  localparam logic [3:0] SEG_LEN = 4'd5;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] dx;
    logic [3:0] dy;
    logic [3:0] lx;
    logic [3:0] ly;
    logic       er;
  } cmd_t;

  typedef struct packed {
    logic [2:0]     cnt;
    cmd_t [6:0]     c;
  } frame_t;

  typedef struct packed {
    logic latch_upd;
    logic reinit;
    logic start_init;
    logic start_frame;
    logic advance;
    logic emit;
    logic frame_end;
  } ctrl_cmd_t;

  typedef struct packed {
    logic busy;
    logic init_done;
    logic cand_valid;
    logic cand_last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [POS_W-1:0] col_x(input logic [DIG_W-1:0] d);
    case (d)
      3'd0: col_x = 7'd0;
      3'd1: col_x = 7'd8;
      3'd2: col_x = 7'd24;
      3'd3: col_x = 7'd32;
      3'd4: col_x = 7'd47;
      3'd5: col_x = 7'd55;
      default: col_x = 7'd0;
    endcase
  endfunction

  function automatic logic [6:0] digit_segs(input logic [3:0] v);
    case (v)
      4'd0: digit_segs = 7'h3F;
      4'd1: digit_segs = 7'h06;
      4'd2: digit_segs = 7'h5B;
      4'd3: digit_segs = 7'h4F;
      4'd4: digit_segs = 7'h66;
      4'd5: digit_segs = 7'h6D;
      4'd6: digit_segs = 7'h7D;
      4'd7: digit_segs = 7'h07;
      4'd8: digit_segs = 7'h7F;
      4'd9: digit_segs = 7'h6F;
      default: digit_segs = 7'h00;
    endcase
  endfunction

  function automatic cmd_t mk(input logic [1:0] op, input logic [3:0] x, input logic [3:0] y,
                              input logic [3:0] lx, input logic [3:0] ly, input logic er);
    cmd_t c;
    c.op = op; c.dx = x; c.dy = y; c.lx = lx; c.ly = ly; c.er = er;
    return c;
  endfunction

  function automatic cmd_t pix(input logic [3:0] x, input logic [3:0] y, input logic er);
    return mk(OP_PIX, x, y, 4'd0, 4'd0, er);
  endfunction

  function automatic cmd_t vl(input logic [3:0] x, input logic [3:0] y, input logic er);
    return mk(OP_LINE, x, y, 4'd0, SEG_LEN, er);
  endfunction

  function automatic cmd_t seg_geo(input logic [2:0] s);
    case (s)
      3'd0: seg_geo = mk(OP_LINE, 4'd2, 4'd13, SEG_LEN, 4'd0, 1'b0);
      3'd1: seg_geo = mk(OP_LINE, 4'd7, 4'd8, 4'd0, SEG_LEN, 1'b0);
      3'd2: seg_geo = mk(OP_LINE, 4'd7, 4'd2, 4'd0, SEG_LEN, 1'b0);
      3'd3: seg_geo = mk(OP_LINE, 4'd2, 4'd1, SEG_LEN, 4'd0, 1'b0);
      3'd4: seg_geo = mk(OP_LINE, 4'd1, 4'd2, 4'd0, SEG_LEN, 1'b0);
      3'd5: seg_geo = mk(OP_LINE, 4'd1, 4'd8, 4'd0, SEG_LEN, 1'b0);
      3'd6: seg_geo = mk(OP_LINE, 4'd2, 4'd7, SEG_LEN, 4'd0, 1'b0);
      default: seg_geo = mk(OP_LINE, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0);
    endcase
  endfunction

  function automatic logic [2:0] frame_count(input logic [3:0] v);
    if (v == 4'd0 || v == 4'd4 || v == 4'd5) frame_count = 3'd5;
    else frame_count = 3'd6;
  endfunction

  // One animation frame of target digit v, commands packed from slot 0.
  function automatic frame_t morph_frame(input logic [3:0] v, input logic [2:0] i);
    frame_t     f;
    logic [3:0] ii;
    f  = '0;
    ii = {1'b0, i};
    case (v)
      4'd0: begin
        f.c[0] = pix(4'd6 - ii, 4'd7, 1'b1);
        f.c[1] = pix(4'd1, 4'd6 - ii, 1'b0);
        f.c[2] = pix(4'd7, 4'd12 - ii, 1'b0);
        f.cnt  = 3'd3;
      end
      4'd1, 4'd7: begin
        f.c[0] = vl(4'd1 + ii, 4'd8, 1'b1);
        f.c[1] = vl(4'd2 + ii, 4'd8, 1'b0);
        f.c[2] = vl(4'd1 + ii, 4'd2, 1'b1);
        f.c[3] = vl(4'd2 + ii, 4'd2, 1'b0);
        f.c[4] = pix(4'd2 + ii, 4'd1, 1'b1);
        f.c[5] = pix(4'd2 + ii, 4'd7, 1'b1);
        f.c[6] = pix(4'd2 + ii, 4'd13, 1'b1);
        f.cnt  = (v == 4'd1) ? 3'd7 : 3'd6;
      end
      4'd2: begin
        if (ii < SEG_LEN) begin
          f.c[0] = pix(4'd6 - ii, 4'd13, 1'b0);
          f.c[1] = pix(4'd6 - ii, 4'd7, 1'b0);
          f.c[2] = pix(4'd6 - ii, 4'd1, 1'b0);
          f.c[3] = vl(4'd7 - ii, 4'd2, 1'b1);
          f.c[4] = vl(4'd6 - ii, 4'd2, 1'b0);
          f.cnt  = 3'd5;
        end else begin
          f.c[0] = vl(4'd7 - ii, 4'd2, 1'b1);
          f.c[1] = vl(4'd6 - ii, 4'd2, 1'b0);
          f.cnt  = 3'd2;
        end
      end
      4'd3, 4'd9: begin
        f.c[0] = vl(4'd1 + ii, 4'd2, 1'b1);
        f.c[1] = vl(4'd2 + ii, 4'd2, 1'b0);
        f.cnt  = 3'd2;
      end
      4'd4: begin
        f.c[0] = pix(4'd6 - ii, 4'd13, 1'b1);
        f.c[1] = pix(4'd1, 4'd12 - ii, 1'b0);
        f.c[2] = pix(4'd2 + ii, 4'd1, 1'b1);
        f.cnt  = 3'd3;
      end
      4'd5: begin
        f.c[0] = pix(4'd7, 4'd8 + ii, 1'b1);
        f.c[1] = pix(4'd6 - ii, 4'd1, 1'b0);
        f.c[2] = pix(4'd6 - ii, 4'd13, 1'b0);
        f.cnt  = 3'd3;
      end
      4'd6: begin
        f.c[0] = vl(4'd6 - ii, 4'd2, 1'b0);
        f.c[1] = vl(4'd7 - ii, 4'd2, 1'b1);
        f.cnt  = (ii != 4'd0) ? 3'd2 : 3'd1;
      end
      4'd8: begin
        if (ii == 4'd0) begin
          f.c[0] = vl(4'd6, 4'd2, 1'b0);
          f.c[1] = vl(4'd6, 4'd8, 1'b0);
          f.c[2] = pix(4'd6, 4'd7, 1'b0);
          f.c[3] = pix(4'd6, 4'd1, 1'b0);
          f.cnt  = 3'd4;
        end else begin
          f.c[0] = vl(4'd6 - ii, 4'd2, 1'b0);
          f.c[1] = vl(4'd7 - ii, 4'd2, 1'b1);
          f.c[2] = vl(4'd6 - ii, 4'd8, 1'b0);
          f.c[3] = vl(4'd7 - ii, 4'd8, 1'b1);
          f.c[4] = pix(4'd6 - ii, 4'd7, 1'b0);
          f.c[5] = pix(4'd6 - ii, 4'd1, 1'b0);
          f.cnt  = (ii < SEG_LEN) ? 3'd6 : 3'd4;
        end
      end
      default: f = '0;
    endcase
    return f;
  endfunction

  // Tens and ones of a value below 64, by a compare chain.
  function automatic logic [7:0] split10(input logic [5:0] val);
    logic [3:0] t;
    logic [5:0] r;
    if (val >= 6'd60)      t = 4'd6;
    else if (val >= 6'd50) t = 4'd5;
    else if (val >= 6'd40) t = 4'd4;
    else if (val >= 6'd30) t = 4'd3;
    else if (val >= 6'd20) t = 4'd2;
    else if (val >= 6'd10) t = 4'd1;
    else                   t = 4'd0;
    r = val - ({2'b00, t} * 6'd10);
    return {t, r[3:0]};
  endfunction

endpackage
`default_nettype wire

// File: rtl/mcdd_ctrl.sv
// Sequencing state machine of the clock drawer: takes input beats and steps
// the datapath through a full redraw or one animation frame. Uses mcdd_pkg.
`default_nettype none
module mcdd_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire [1:0]               kind,
  input  mcdd_pkg::dp_stat_t      stat,
  output mcdd_pkg::ctrl_cmd_t     cmd
);
  import mcdd_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_INIT  = 2'd1;
  localparam logic [1:0] ST_FRAME = 2'd2;

  logic [1:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (kind == KIND_UPD && !stat.busy) begin
            cmd.latch_upd = 1'b1;
            if (!stat.init_done) begin
              cmd.start_init = 1'b1;
              state_next     = ST_INIT;
            end
          end else if (kind == KIND_TICK && stat.busy) begin
            cmd.start_frame = 1'b1;
            state_next      = ST_FRAME;
          end else if (kind == KIND_REINIT) begin
            cmd.reinit = 1'b1;
          end
        end
      end
      ST_INIT: begin
        // skip unlit segments, otherwise wait for a free output slot
        if (!stat.cand_valid) begin
          cmd.advance = 1'b1;
        end else if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.advance = 1'b1;
          if (stat.cand_last) state_next = ST_IDLE;
        end
      end
      ST_FRAME: begin
        if (stat.cand_valid && stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.advance = 1'b1;
          if (stat.cand_last) begin
            cmd.frame_end = 1'b1;
            state_next    = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/mcdd_dp.sv
// Datapath of the clock drawer: digit state, animation queue, command
// generation and the output register. Uses mcdd_pkg.
`default_nettype none
module mcdd_dp #(
  parameter int COLOR_WIDTH = mcdd_pkg::COLOR_WIDTH_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  mcdd_pkg::ctrl_cmd_t     cmd,
  output mcdd_pkg::dp_stat_t      stat,
  input  wire                     cfg_valid,
  input  wire [6:0]               cfg_data,
  input  wire [4:0]               hours,
  input  wire [5:0]               minutes,
  input  wire [5:0]               seconds,
  input  wire [15:0]              draw_color,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [1:0]              op,
  output logic [6:0]              pos_x,
  output logic [6:0]              pos_y,
  output logic [3:0]              len_x,
  output logic [3:0]              len_y,
  output logic                    erase,
  output logic [15:0]             color_out,
  output logic                    last
);
  import mcdd_pkg::*;

  localparam logic [15:0] COLOR_MASK =
    (COLOR_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << COLOR_WIDTH) - 32'd1);

  logic [6:0]             row_base;
  logic [3:0]             shown [NUM_DIGITS];
  logic                   init_done;
  logic [NUM_DIGITS-1:0]  pending;
  logic [2:0]             frame_idx;
  logic [15:0]            latched_color;
  logic                   mode_init;
  logic [1:0]             ph;
  logic [DIG_W-1:0]       dig;
  logic [2:0]             seg;

  logic [3:0]             dg [NUM_DIGITS];
  logic [7:0]             sp_h, sp_m, sp_s;
  logic [DIG_W-1:0]       hp;
  logic [3:0]             hp_val, init_val;
  logic [6:0]             init_segs, segs_above;
  frame_t                 fr;
  cmd_t                   cand;
  logic                   cand_valid, cand_last;
  logic [DIG_W-1:0]       cand_dig;
  logic [2:0]             fi_inc;

  assign sp_h  = split10(6'(hours));
  assign sp_m  = split10(minutes);
  assign sp_s  = split10(seconds);
  assign dg[0] = sp_h[7:4];
  assign dg[1] = sp_h[3:0];
  assign dg[2] = sp_m[7:4];
  assign dg[3] = sp_m[3:0];
  assign dg[4] = sp_s[7:4];
  assign dg[5] = sp_s[3:0];

  always_comb begin
    hp = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (pending[d]) hp = DIG_W'(d);
    end
  end

  assign hp_val     = shown[hp];
  assign init_val   = shown[dig];
  assign init_segs  = digit_segs(init_val);
  assign segs_above = (init_segs >> seg) >> 1;
  assign fr         = morph_frame(hp_val, frame_idx);
  assign fi_inc     = frame_idx + 3'd1;

  always_comb begin
    if (mode_init) begin
      cand_dig = dig;
      if (ph != 2'd2) begin
        cand       = mk(OP_BG, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0);
        cand_valid = 1'b1;
        cand_last  = 1'b0;
      end else begin
        cand       = seg_geo(seg);
        cand_valid = init_segs[seg];
        cand_last  = (dig == DIG_W'(NUM_DIGITS - 1)) && (segs_above == 7'd0);
      end
    end else begin
      cand_dig   = hp;
      cand       = fr.c[seg];
      cand_valid = seg < fr.cnt;
      cand_last  = seg == (fr.cnt - 3'd1);
    end
  end

  assign stat.busy       = pending != '0;
  assign stat.init_done  = init_done;
  assign stat.cand_valid = cand_valid;
  assign stat.cand_last  = cand_last;
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_base      <= '0;
      init_done     <= 1'b0;
      pending       <= '0;
      frame_idx     <= '0;
      latched_color <= '0;
      mode_init     <= 1'b0;
      ph            <= '0;
      dig           <= '0;
      seg           <= '0;
      out_valid     <= 1'b0;
      for (int d = 0; d < NUM_DIGITS; d++) shown[d] <= '0;
    end else begin
      if (cfg_valid) row_base <= cfg_data;
      if (cmd.reinit) begin
        init_done <= 1'b0;
        pending   <= '0;
        frame_idx <= '0;
      end
      if (cmd.latch_upd) begin
        latched_color <= draw_color;
        frame_idx     <= '0;
        init_done     <= 1'b1;
        for (int d = 0; d < NUM_DIGITS; d++) begin
          shown[d] <= dg[d];
          if (init_done && shown[d] != dg[d]) pending[d] <= 1'b1;
        end
      end
      if (cmd.start_init || cmd.start_frame) begin
        mode_init <= cmd.start_init;
        ph        <= '0;
        dig       <= '0;
        seg       <= '0;
      end else if (cmd.advance) begin
        if (!mode_init) begin
          seg <= seg + 3'd1;
        end else if (ph != 2'd2) begin
          ph <= ph + 2'd1;
        end else if (seg == 3'd6) begin
          seg <= '0;
          dig <= dig + DIG_W'(1);
        end else begin
          seg <= seg + 3'd1;
        end
      end
      // finish the frame: retire the digit once its animation is over
      if (cmd.frame_end) begin
        if (fi_inc >= frame_count(hp_val)) begin
          pending[hp] <= 1'b0;
          frame_idx   <= '0;
        end else begin
          frame_idx <= fi_inc;
        end
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      op        <= cand.op;
      len_x     <= cand.lx;
      len_y     <= cand.ly;
      erase     <= cand.er;
      last      <= cand_last;
      color_out <= latched_color & COLOR_MASK;
      if (cand.op == OP_BG) begin
        pos_x <= 7'(ph);
        pos_y <= '0;
      end else begin
        pos_x <= col_x(cand_dig) + 7'(cand.dx);
        pos_y <= row_base + 7'(cand.dy);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/morphing_clock_digit_drawer_unit.sv
// Morphing clock digit drawer: one item at a time. A first time update emits
// 2 background beats and walks up to 42 segment slots, one a cycle; a tick
// emits its frame's 1 to 7 commands one per cycle.
// Output stalls hold the sequencer in place.
// Reset (rst, synchronous) clears digits, queue, color and row_base to zero.
`default_nettype none
module morphing_clock_digit_drawer_unit #(
  parameter int COLOR_WIDTH = mcdd_pkg::COLOR_WIDTH_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [6:0]   cfg_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire [1:0]   kind,
  input  wire [4:0]   hours,
  input  wire [5:0]   minutes,
  input  wire [5:0]   seconds,
  input  wire [15:0]  draw_color,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  op,
  output logic [6:0]  pos_x,
  output logic [6:0]  pos_y,
  output logic [3:0]  len_x,
  output logic [3:0]  len_y,
  output logic        erase,
  output logic [15:0] color_out,
  output logic        last
);
  import mcdd_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  mcdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .stat     (stat),
    .cmd      (cmd)
  );

  mcdd_dp #(.COLOR_WIDTH(COLOR_WIDTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .hours      (hours),
    .minutes    (minutes),
    .seconds    (seconds),
    .draw_color (draw_color),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .op         (op),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .len_x      (len_x),
    .len_y      (len_y),
    .erase      (erase),
    .color_out  (color_out),
    .last       (last)
  );

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("command loaded while output beat still held");

  a_reinit_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind == KIND_REINIT) |=> (!stat.busy && !stat.init_done))
    else $error("reinit left animation queue or init flag set");

  a_ready_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !cmd.emit)
    else $error("command emitted while accepting input");
`endif

endmodule
`default_nettype wire
